>>> hw/rtl/fss_pkg.sv
// Shared types, codes and defaults for the feature statistics standardizer.
package fss_pkg;
  localparam int FEATURES_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    REQ_ACC = 3'd0,
    REQ_FIN = 3'd1,
    REQ_LOAD = 3'd2,
    REQ_STD = 3'd3,
    REQ_CLR = 3'd4
  } req_t;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_FEW = 2'd1;
  localparam logic [1:0] ERR_SAT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input word
    logic rd;        // issue table reads
    logic prep;      // set up operation from read data
    logic div_go;    // start divider
    logic mul_go;    // start product
    logic sqrt_go;
    logic wr_acc;    // write running tables
    logic wr_app;    // write apply tables
    logic emit;      // result strobe
  } fss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic mul_done;
  } fss_sts_t;
endpackage

>>> hw/rtl/fss_ctrl.sv
// Controller state machine sequencing one request through the datapath.
module fss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        req,
  input  logic              skip_div,
  output logic              busy,
  output fss_pkg::fss_cmd_t cmd,
  input  fss_pkg::fss_sts_t sts
);
  import fss_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_PREP = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_SQRT = 9'b000100000,
    S_WAIT = 9'b001000000,
    S_WR   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      req_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && start) req_r <= req;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        case (req_r)
          REQ_ACC, REQ_FIN, REQ_STD: state_nxt = skip_div ? S_WR : S_DIV;
          default: state_nxt = S_WR;
        endcase
        if (!skip_div && (req_r == REQ_ACC || req_r == REQ_FIN || req_r == REQ_STD))
          cmd.div_go = 1'b1;
      end
      S_DIV: begin
        if (sts.div_done) begin
          case (req_r)
            REQ_ACC: begin
              cmd.mul_go = 1'b1;
              state_nxt = S_MUL;
            end
            REQ_FIN: begin
              cmd.sqrt_go = 1'b1;
              state_nxt = S_SQRT;
            end
            default: state_nxt = S_WR;
          endcase
        end
      end
      S_MUL: if (sts.mul_done) state_nxt = S_WAIT;
      S_SQRT: if (sts.sqrt_done) state_nxt = S_WR;
      S_WAIT: state_nxt = S_WR;
      S_WR: begin
        cmd.wr_acc = (req_r == REQ_ACC);
        cmd.wr_app = (req_r == REQ_FIN) || (req_r == REQ_LOAD);
        state_nxt = (req_r == REQ_FIN || req_r == REQ_STD) ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
endmodule

>>> hw/rtl/fss_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module fss_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [63:0] q_r, rem_r, den_r;
  logic [6:0] cnt_r;
  logic run_r, done_r;
  logic [64:0] trial;

  assign trial = {rem_r, q_r[63]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= 7'd64;
      end else if (run_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      if (!trial[64]) begin
        rem_r <= trial[63:0];
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[62:0], q_r[63]};
        q_r <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

>>> hw/rtl/fss_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
module fss_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] v_r;
  logic [31:0] res_r;
  logic [33:0] rem_r;
  logic [5:0] cnt_r;
  logic run_r, done_r;
  logic [33:0] cur, trial;

  assign cur = {rem_r[31:0], v_r[63:62]};
  assign trial = cur - {res_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= 6'd32;
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      v_r <= rad;
      res_r <= '0;
      rem_r <= '0;
    end else if (run_r) begin
      v_r <= {v_r[61:0], 2'b00};
      if (cur >= {res_r, 2'b01}) begin
        rem_r <= trial;
        res_r <= {res_r[30:0], 1'b1};
      end else begin
        rem_r <= cur;
        res_r <= {res_r[30:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = res_r;
endmodule

>>> hw/rtl/fss_dp.sv
// Datapath: statistic tables, step count, divider, square root and result word.
module fss_dp #(
  parameter int FEATURES = fss_pkg::FEATURES_DEF,
  parameter int FRAC_BITS = fss_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fss_pkg::fss_cmd_t cmd,
  output fss_pkg::fss_sts_t sts,
  output logic              skip_div,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_feature,
  input  logic signed [31:0] in_value,
  input  logic [30:0]       in_spread,
  input  logic              in_step_end,
  output logic              out_valid,
  output logic [7:0]        out_result_feature,
  output logic signed [31:0] out_result_value,
  output logic [30:0]       out_result_spread,
  output logic [1:0]        out_error
);
  import fss_pkg::*;

  localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  logic [31:0] rmean_mem [FEATURES];
  logic [63:0] dsum_mem [FEATURES];
  logic [31:0] amean_mem [FEATURES];
  logic [30:0] asd_mem [FEATURES];

  logic [2:0] req_r;
  logic [7:0] feat_r;
  logic signed [31:0] x_r;
  logic [30:0] spread_r;
  logic step_end_r;
  logic [AW-1:0] addr_r;
  logic [31:0] cnt_r;

  logic [31:0] rmean_q, amean_q;
  logic [63:0] dsum_q;
  logic [30:0] asd_q;

  logic d_neg_r;
  logic [32:0] dmag_r;
  logic [63:0] num_r, den_r;
  logic div_go_r;
  logic [31:0] newmean_r;
  logic [32:0] emag_r;
  logic [63:0] prod_r;
  logic [63:0] newsum_r;
  logic [31:0] fsd_r;
  logic [1:0] err_r;
  logic signed [31:0] rv_r;
  logic few_r, sdz_r;

  logic div_done, sqrt_done;
  logic [63:0] quo;
  logic [31:0] root;
  logic mul_done_r, mul_ph_r;

  // feature index folded onto the table depth
  logic [AW-1:0] addr_in;
  logic [AW-1:0] mod_tab [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_mod
    assign mod_tab[gi] = AW'(gi % FEATURES);
  end
  assign addr_in = mod_tab[in_feature];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      feat_r <= in_feature;
      x_r <= in_value;
      spread_r <= in_spread;
      step_end_r <= in_step_end;
      addr_r <= addr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rmean_q <= rmean_mem[addr_r];
      dsum_q <= dsum_mem[addr_r];
      amean_q <= amean_mem[addr_r];
      asd_q <= asd_mem[addr_r];
    end
  end

  logic signed [32:0] d_acc, d_std;
  assign d_acc = 33'(x_r) - 33'($signed(rmean_q));
  assign d_std = 33'(x_r) - 33'($signed(amean_q));

  always_comb begin
    skip_div = 1'b0;
    case (req_r)
      REQ_ACC: skip_div = (cnt_r == 32'd0);
      REQ_FIN: skip_div = (cnt_r < 32'd2);
      REQ_STD: skip_div = (asd_q == 31'd0);
      default: skip_div = 1'b0;
    endcase
  end

  // operation setup
  always_ff @(posedge clk) begin
    div_go_r <= cmd.div_go;
    if (cmd.prep) begin
      few_r <= (cnt_r < 32'd2);
      sdz_r <= (asd_q == 31'd0);
      case (req_r)
        REQ_ACC: begin
          d_neg_r <= d_acc[32];
          dmag_r <= d_acc[32] ? 33'(-d_acc) : 33'(d_acc);
          num_r <= {31'd0, d_acc[32] ? 33'(-d_acc) : 33'(d_acc)};
          den_r <= {32'd0, cnt_r} + 64'd1;
        end
        REQ_FIN: begin
          num_r <= dsum_q;
          den_r <= {32'd0, cnt_r} - 64'd1;
        end
        default: begin
          d_neg_r <= d_std[32];
          dmag_r <= d_std[32] ? 33'(-d_std) : 33'(d_std);
          num_r <= 64'(d_std[32] ? 33'(-d_std) : 33'(d_std)) << FRAC_BITS;
          den_r <= {33'd0, asd_q};
        end
      endcase
    end
  end

  fss_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go_r), .num(num_r), .den(den_r),
    .done(div_done), .quo(quo)
  );

  fss_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .go(cmd.sqrt_go), .rad(quo),
    .done(sqrt_done), .root(root)
  );

  // accumulate: new mean, then product of magnitudes, then saturating sum
  logic signed [33:0] mn_w, e_w;
  logic [32:0] emag_w;
  logic [64:0] sum_w;
  assign mn_w = d_neg_r ? 34'($signed(rmean_q)) - 34'(quo[32:0])
                        : 34'($signed(rmean_q)) + 34'(quo[32:0]);
  assign e_w = 34'(x_r) - mn_w;
  assign emag_w = e_w[33] ? 33'(-e_w) : 33'(e_w);
  assign sum_w = {1'b0, dsum_q} + {1'b0, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_ph_r <= 1'b0;
      mul_done_r <= 1'b0;
    end else begin
      mul_done_r <= mul_ph_r;
      mul_ph_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      newmean_r <= mn_w[31:0];
      emag_r <= emag_w;
    end
    if (mul_ph_r) prod_r <= 64'(dmag_r) * 64'(emag_r);
    if (mul_done_r) newsum_r <= sum_w[64] ? '1 : sum_w[63:0];
  end

  // result formation
  always_ff @(posedge clk) begin
    if (sqrt_done) fsd_r <= root;
    if (cmd.wr_acc) begin
      if (cnt_r == 32'd0) begin
        rmean_mem[addr_r] <= x_r;
        dsum_mem[addr_r] <= '0;
      end else begin
        rmean_mem[addr_r] <= newmean_r;
        dsum_mem[addr_r] <= newsum_r;
      end
    end
    if (cmd.wr_app) begin
      if (req_r == REQ_LOAD) begin
        amean_mem[addr_r] <= x_r;
        asd_mem[addr_r] <= spread_r;
      end else if (!few_r) begin
        amean_mem[addr_r] <= rmean_q;
        asd_mem[addr_r] <= fsd_r[31] ? 31'h7FFFFFFF : fsd_r[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.capture && in_req_type == REQ_CLR) begin
      cnt_r <= '0;
    end else if (cmd.wr_acc && step_end_r && cnt_r != 32'hFFFFFFFF) begin
      cnt_r <= cnt_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_acc || cmd.wr_app || (cmd.emit == 1'b0 && req_r == REQ_STD)) begin
      if (req_r == REQ_FIN) begin
        if (few_r) begin
          rv_r <= '0;
          out_result_spread <= '0;
          err_r <= ERR_FEW;
        end else begin
          rv_r <= rmean_q;
          out_result_spread <= fsd_r[31] ? 31'h7FFFFFFF : fsd_r[30:0];
          err_r <= (fsd_r[31] || fsd_r == 32'd0) ? ERR_SAT : ERR_OK;
        end
      end else if (req_r == REQ_STD) begin
        out_result_spread <= '0;
        if (sdz_r) begin
          rv_r <= '0;
          err_r <= ERR_SAT;
        end else if (d_neg_r) begin
          if (quo > 64'h80000000) begin
            rv_r <= 32'sh80000000;
            err_r <= ERR_SAT;
          end else begin
            rv_r <= 32'(-quo[31:0]);
            err_r <= ERR_OK;
          end
        end else begin
          if (quo > 64'h7FFFFFFF) begin
            rv_r <= 32'sh7FFFFFFF;
            err_r <= ERR_SAT;
          end else begin
            rv_r <= quo[31:0];
            err_r <= ERR_OK;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_result_feature <= feat_r;
      out_result_value <= rv_r;
      out_error <= err_r;
    end
  end

  assign sts.div_done = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.mul_done = mul_done_r;
endmodule

>>> hw/rtl/feature_stats_standardizer.sv
// Top level: per-feature Welford statistics, finalize and standardize.
// Busy from accept until the word is done; accumulate skips the divider on a first step,
// finalize with too few samples and standardize with zero deviation skip it too;
// out_valid rises, for finalize and standardize only, in the same cycle busy falls.
// One word in flight; the next word is taken from the cycle busy falls. Receiver cannot stall.
// Synchronous active-low reset clears control, step count and strobe, not the tables.
module feature_stats_standardizer #(
  parameter int FEATURES = fss_pkg::FEATURES_DEF,
  parameter int FRAC_BITS = fss_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_feature,
  input  logic signed [31:0] in_value,
  input  logic [30:0]       in_spread,
  input  logic              in_step_end,
  output logic              out_valid,
  output logic [7:0]        out_result_feature,
  output logic signed [31:0] out_result_value,
  output logic [30:0]       out_result_spread,
  output logic [1:0]        out_error
);
  import fss_pkg::*;

  fss_cmd_t cmd;
  fss_sts_t sts;
  logic skip_div;
  logic out_strobe_d;

  fss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req(in_req_type),
    .skip_div(skip_div), .busy(busy), .cmd(cmd), .sts(sts)
  );

  fss_dp #(.FEATURES(FEATURES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .skip_div(skip_div),
    .in_req_type(in_req_type), .in_feature(in_feature), .in_value(in_value),
    .in_spread(in_spread), .in_step_end(in_step_end),
    .out_valid(out_strobe_d), .out_result_feature(out_result_feature),
    .out_result_value(out_result_value), .out_result_spread(out_result_spread),
    .out_error(out_error)
  );

  assign out_valid = out_strobe_d;
endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for feature_stats_standardizer: directed table, then random sessions and words.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fss_pkg::*;

  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int ITEMS = 1450;
  localparam int LIMIT = 2000000;
  localparam int TAIL = 150;

  typedef struct packed {
    logic [7:0]  feat;
    logic [31:0] val;
    logic [30:0] spr;
    logic [1:0]  err;
  } res_t;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  feat;
    logic [31:0] val;
    logic [30:0] spr;
    logic        se;
    logic        typed;
    res_t        exp;
  } word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0] in_req_type = '0;
  logic [7:0] in_feature = '0;
  logic signed [31:0] in_value = '0;
  logic [30:0] in_spread = '0;
  logic in_step_end = 0;
  logic out_valid;
  logic [7:0] out_result_feature;
  logic signed [31:0] out_result_value;
  logic [30:0] out_result_spread;
  logic [1:0] out_error;

  feature_stats_standardizer dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [31:0] step_cnt;
  logic [31:0] run_mean [256];
  logic [63:0] dev_sum [256];
  logic [31:0] app_mean [256];
  logic [30:0] app_sd [256];
  bit run_wr [256];
  bit app_wr [256];
  logic [7:0] run_list [$];
  logic [7:0] app_list [$];

  res_t pending_results [$];
  int errors = 0;
  int sent = 0;
  int idle_pct = 14;
  longint unsigned cycles = 0;
  word_t dir_tab [$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic predict(word_t w);
    longint x, m, d, mn;
    logic [63:0] q, prod, vr, sd;
    logic [64:0] s;
    int f;
    res_t r;
    f = w.feat;
    x = longint'($signed(w.val));
    r = '0;
    r.feat = w.feat;
    case (w.req)
      REQ_ACC: begin
        if (step_cnt == 0) begin
          run_mean[f] = w.val;
          dev_sum[f] = 0;
        end else begin
          m = longint'($signed(run_mean[f]));
          d = x - m;
          q = mag(d) / ({32'b0, step_cnt} + 64'd1);
          mn = d < 0 ? m - longint'(q) : m + longint'(q);
          prod = mag(d) * mag(x - mn);
          s = {1'b0, dev_sum[f]} + {1'b0, prod};
          dev_sum[f] = s[64] ? '1 : s[63:0];
          run_mean[f] = mn[31:0];
        end
        if (!run_wr[f]) begin
          run_wr[f] = 1;
          run_list.push_back(w.feat);
        end
        if (w.se && step_cnt != '1) step_cnt = step_cnt + 1;
      end
      REQ_FIN: begin
        if (step_cnt < 2) begin
          r.err = ERR_FEW;
        end else begin
          vr = dev_sum[f] / ({32'b0, step_cnt} - 64'd1);
          sd = int_sqrt(vr);
          r.err = ERR_OK;
          if (sd > 64'h7FFF_FFFF) begin
            sd = 64'h7FFF_FFFF;
            r.err = ERR_SAT;
          end
          if (sd == 0) r.err = ERR_SAT;
          app_mean[f] = run_mean[f];
          app_sd[f] = sd[30:0];
          if (!app_wr[f]) begin
            app_wr[f] = 1;
            app_list.push_back(w.feat);
          end
          r.val = run_mean[f];
          r.spr = sd[30:0];
        end
      end
      REQ_LOAD: begin
        app_mean[f] = w.val;
        app_sd[f] = w.spr;
        if (!app_wr[f]) begin
          app_wr[f] = 1;
          app_list.push_back(w.feat);
        end
      end
      REQ_STD: begin
        if (app_sd[f] == 0) begin
          r.err = ERR_SAT;
        end else begin
          d = x - longint'($signed(app_mean[f]));
          q = (mag(d) << FRAC_BITS_DEF) / {33'b0, app_sd[f]};
          r.err = ERR_OK;
          if (d < 0) begin
            if (q > 64'h8000_0000) begin
              q = 64'h8000_0000;
              r.err = ERR_SAT;
            end
            r.val = 32'(-longint'(q));
          end else begin
            if (q > 64'h7FFF_FFFF) begin
              q = 64'h7FFF_FFFF;
              r.err = ERR_SAT;
            end
            r.val = q[31:0];
          end
        end
      end
      REQ_CLR: step_cnt = 0;
      default: ;
    endcase
    if (w.req == REQ_FIN || w.req == REQ_STD)
      pending_results.push_back(w.typed ? w.exp : r);
  endtask

  task automatic send(word_t w);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_req_type = w.req;
    in_feature = w.feat;
    in_value = w.val;
    in_spread = w.spr;
    in_step_end = w.se;
    start = 1;
    do @(posedge clk); while (busy);
    predict(w);
    sent++;
  endtask

  // keeps every table read whose value is used on an entry already written
  task automatic send_legal(word_t w);
    if (w.req == REQ_ACC && step_cnt != 0 && !run_wr[w.feat])
      w.feat = run_list[$urandom_range(run_list.size() - 1)];
    if (w.req == REQ_FIN && step_cnt >= 2 && !run_wr[w.feat])
      w.feat = run_list[$urandom_range(run_list.size() - 1)];
    if (w.req == REQ_STD && !app_wr[w.feat]) begin
      if (app_list.size() == 0) w.req = REQ_LOAD;
      else w.feat = app_list[$urandom_range(app_list.size() - 1)];
    end
    send(w);
  endtask

  function automatic logic [31:0] rand_val(logic [31:0] base, int sc);
    case (sc)
      0: return base;
      1: return base + 32'($urandom_range(0, 511)) - 32'd256;
      2: return base + 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t mk(logic [2:0] rq, logic [7:0] ft, logic [31:0] v,
                               logic [30:0] sp, int se, int ty, res_t ex);
    word_t w;
    w.req = rq; w.feat = ft; w.val = v; w.spr = sp; w.se = 1'(se); w.typed = 1'(ty);
    w.exp = ex;
    return w;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w = '0;
    w.req = 3'($urandom_range(0, 7));
    w.feat = 8'($urandom);
    w.val = rand_val(32'($urandom_range(0, 1 << 22)), $urandom_range(1, 3));
    w.spr = ($urandom_range(1)) ? 31'($urandom) : 31'($urandom_range(1, 1 << 20));
    w.se = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic session();
    logic [7:0] fs [$];
    logic [31:0] bases [$];
    int scs [$];
    int nf, ns;
    word_t w;
    send(mk(REQ_CLR, 8'($urandom), $urandom, 31'($urandom), $urandom_range(1), 0, '0));
    nf = $urandom_range(1, 5);
    ns = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 7);
    for (int i = 0; i < nf; i++) begin
      fs.push_back(8'($urandom));
      bases.push_back($urandom_range(1) ? $urandom : 32'($urandom_range(0, 1 << 20)));
      scs.push_back($urandom_range(0, 3));
    end
    for (int s = 0; s < ns; s++)
      for (int i = 0; i < nf; i++)
        send_legal(mk(REQ_ACC, fs[i], rand_val(bases[i], scs[i]), 31'($urandom),
                      i == nf - 1, 0, '0));
    for (int i = 0; i < nf; i++)
      if ($urandom_range(9) < 8) send_legal(mk(REQ_FIN, fs[i], $urandom, 31'($urandom),
                                               $urandom_range(1), 0, '0));
    repeat ($urandom_range(3, 8)) begin
      w = mk(REQ_STD, fs[$urandom_range(nf - 1)], 32'd0, 31'($urandom), $urandom_range(1),
             0, '0);
      w.val = rand_val(bases[$urandom_range(nf - 1)], $urandom_range(1, 3));
      if ($urandom_range(5) == 0) begin
        w.req = REQ_LOAD;
        w.spr = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
      end
      send_legal(w);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result feat=%h val=%h spr=%h err=%h", $time,
                 out_result_feature, out_result_value, out_result_spread, out_error);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_result_feature !== e.feat) begin
          $display("%0t: feature exp %h got %h", $time, e.feat, out_result_feature);
          errors++;
        end
        if (out_result_value !== e.val) begin
          $display("%0t: value exp %h got %h", $time, e.val, out_result_value);
          errors++;
        end
        if (out_result_spread !== e.spr) begin
          $display("%0t: spread exp %h got %h", $time, e.spr, out_result_spread);
          errors++;
        end
        if (out_error !== e.err) begin
          $display("%0t: error exp %h got %h", $time, e.err, out_error);
          errors++;
        end
      end
    end
  end

  initial begin
    step_cnt = 0;
    foreach (run_wr[i]) begin
      run_wr[i] = 0;
      app_wr[i] = 0;
      run_mean[i] = 0;
      dev_sum[i] = 0;
      app_mean[i] = 0;
      app_sd[i] = 0;
    end
    dir_tab.push_back(mk(REQ_FIN, 8'd0, 32'd0, 31'd0, 1, 1, '{8'd0, 32'd0, 31'd0, ERR_FEW}));
    dir_tab.push_back(mk(REQ_LOAD, 8'd5, 32'd0, 31'd0, 1, 0, '0));
    dir_tab.push_back(mk(REQ_STD, 8'd5, 32'd123, 31'd0, 0, 1,
                         '{8'd5, 32'd0, 31'd0, ERR_SAT}));
    dir_tab.push_back(mk(REQ_LOAD, 8'd6, 32'd0, 31'h10000, 0, 0, '0));
    dir_tab.push_back(mk(REQ_STD, 8'd6, 32'h7FFF_FFFF, 31'd0, 0, 1,
                         '{8'd6, 32'h7FFF_FFFF, 31'd0, ERR_OK}));
    dir_tab.push_back(mk(REQ_STD, 8'd6, 32'h8000_0000, 31'd0, 0, 1,
                         '{8'd6, 32'h8000_0000, 31'd0, ERR_OK}));
    dir_tab.push_back(mk(REQ_LOAD, 8'd7, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, '0));
    dir_tab.push_back(mk(REQ_STD, 8'd7, 32'h8000_0000, 31'd0, 0, 0, '0));
    dir_tab.push_back(mk(REQ_ACC, 8'd255, 32'h7FFF_FFFF, 31'd0, 1, 0, '0));
    dir_tab.push_back(mk(REQ_FIN, 8'd255, 32'd0, 31'd0, 0, 1,
                         '{8'd255, 32'd0, 31'd0, ERR_FEW}));
    dir_tab.push_back(mk(REQ_ACC, 8'd255, 32'h8000_0000, 31'h7FFF_FFFF, 1, 0, '0));
    dir_tab.push_back(mk(REQ_FIN, 8'd255, 32'd0, 31'd0, 0, 0, '0));
    dir_tab.push_back(mk(REQ_STD, 8'd255, 32'd0, 31'd0, 0, 0, '0));
    dir_tab.push_back(mk(REQ_CLR, 8'd0, 32'd0, 31'd0, 1, 0, '0));
    dir_tab.push_back(mk(REQ_ACC, 8'd1, 32'h30000, 31'd0, 0, 0, '0));
    dir_tab.push_back(mk(REQ_ACC, 8'd2, 32'hFFFB_0000, 31'd0, 1, 0, '0));
    dir_tab.push_back(mk(REQ_ACC, 8'd1, 32'h30000, 31'd0, 0, 0, '0));
    dir_tab.push_back(mk(REQ_ACC, 8'd2, 32'h70000, 31'd0, 1, 0, '0));
    dir_tab.push_back(mk(REQ_ACC, 8'd1, 32'h30000, 31'd0, 1, 0, '0));
    dir_tab.push_back(mk(REQ_FIN, 8'd1, 32'd0, 31'd0, 0, 0, '0));
    dir_tab.push_back(mk(REQ_FIN, 8'd2, 32'd0, 31'd0, 0, 0, '0));
    dir_tab.push_back(mk(REQ_STD, 8'd2, 32'h10000, 31'd0, 0, 0, '0));
    dir_tab.push_back(mk(REQ_SPARE_LO, 8'd3, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1, 0, '0));
    dir_tab.push_back(mk(REQ_SPARE_HI, 8'd4, 32'd0, 31'd0, 1, 0, '0));
    dir_tab.push_back(mk(REQ_STD, 8'd1, 32'h30000, 31'd0, 0, 1,
                         '{8'd1, 32'd0, 31'd0, ERR_SAT}));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (dir_tab[i]) send(dir_tab[i]);

    while (sent < ITEMS) begin
      if (sent > ITEMS * 2 / 3) idle_pct = 0;
      else if (sent > ITEMS / 3) idle_pct = 70;
      if ($urandom_range(3) != 0) session();
      else repeat ($urandom_range(1, 5)) send_legal(rand_word());
    end
    @(negedge clk);
    start = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
